// ----- rtl/rdpm_pkg.sv -----
// Shared constants, types and opcodes for the rational dot-product MAC.
package rdpm_pkg;

  localparam int unsigned InWidthDef  = 32;
  localparam int unsigned AccWidthDef = 64;

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    OP_GCD = 2'd0,
    OP_DIV = 2'd1,
    OP_MUL = 2'd2
  } op_t;

  // Request from sequencer to unit.
  typedef struct packed {
    logic start;
    op_t  op;
  } unit_req_t;

  // Status from unit to sequencer.
  typedef struct packed {
    logic done;
    logic ovf;
  } unit_stat_t;

endpackage

// ----- rtl/rdpm_unit.sv -----
// Shared iterative unit: binary gcd, restoring divide, shift-add multiply.
module rdpm_unit import rdpm_pkg::*; #(
  parameter int unsigned ACC_WIDTH = AccWidthDef
) (
  input  logic                 clk,
  input  logic                 rst,
  input  unit_req_t            req,
  input  logic [ACC_WIDTH-1:0] opa,
  input  logic [ACC_WIDTH-1:0] opb,
  output unit_stat_t           stat,
  output logic [ACC_WIDTH-1:0] res
);

  localparam int unsigned CW = $clog2(ACC_WIDTH + 1);

  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_GCD  = 4'b0010,
    U_DIV  = 4'b0100,
    U_MUL  = 4'b1000
  } ustate_t;

  ustate_t              state;
  logic [ACC_WIDTH-1:0] x, y, q;
  logic [ACC_WIDTH:0]   rem;
  logic [CW-1:0]        shift, cnt;
  logic                 ovf;

  logic [ACC_WIDTH:0]   rem_sh;
  logic [ACC_WIDTH:0]   sum_w;
  logic [ACC_WIDTH-1:0] diff;

  assign rem_sh = {rem[ACC_WIDTH-1:0], q[ACC_WIDTH-1]};
  assign sum_w  = {1'b0, q} + {1'b0, x};
  assign diff   = (x > y) ? x - y : y - x;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      stat  <= '0;
    end else begin
      stat.done <= 1'b0;
      unique case (state)
        U_IDLE: begin
          if (req.start) begin
            x     <= opa;
            y     <= opb;
            shift <= '0;
            cnt   <= '0;
            ovf   <= 1'b0;
            rem   <= '0;
            unique case (req.op)
              OP_GCD: begin
                if (opa == '0 || opb == '0) begin
                  res       <= opa | opb;
                  stat.done <= 1'b1;
                  stat.ovf  <= 1'b0;
                end else begin
                  state <= U_GCD;
                end
              end
              OP_DIV: begin
                q     <= opa;
                state <= U_DIV;
              end
              OP_MUL: begin
                q     <= '0;
                state <= U_MUL;
              end
              default: state <= U_IDLE;
            endcase
          end
        end
        // Stein's algorithm: one step per cycle.
        U_GCD: begin
          if (x == y) begin
            res       <= x << shift;
            stat.done <= 1'b1;
            stat.ovf  <= 1'b0;
            state     <= U_IDLE;
          end else if (!x[0] && !y[0]) begin
            x     <= x >> 1;
            y     <= y >> 1;
            shift <= shift + 1'b1;
          end else if (!x[0]) begin
            x <= x >> 1;
          end else if (!y[0]) begin
            y <= y >> 1;
          end else if (x > y) begin
            x <= diff;
          end else begin
            y <= diff;
          end
        end
        // Restoring division, one quotient bit per cycle; q shifts out dividend.
        U_DIV: begin
          if (rem_sh >= {1'b0, y}) begin
            rem <= rem_sh - {1'b0, y};
            q   <= {q[ACC_WIDTH-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            q   <= {q[ACC_WIDTH-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CW'(ACC_WIDTH - 1)) begin
            res       <= (rem_sh >= {1'b0, y}) ? {q[ACC_WIDTH-2:0], 1'b1}
                                               : {q[ACC_WIDTH-2:0], 1'b0};
            stat.done <= 1'b1;
            stat.ovf  <= 1'b0;
            state     <= U_IDLE;
          end
        end
        // Shift-add multiply: x doubles, y halves; overflow when bits fall out.
        U_MUL: begin
          if (y == '0) begin
            res       <= q;
            stat.done <= 1'b1;
            stat.ovf  <= ovf;
            state     <= U_IDLE;
          end else begin
            if (y[0]) begin
              q <= sum_w[ACC_WIDTH-1:0];
              if (sum_w[ACC_WIDTH]) ovf <= 1'b1;
            end
            y <= y >> 1;
            if (y[ACC_WIDTH-1:1] != '0) begin
              if (x[ACC_WIDTH-1]) ovf <= 1'b1;
              x <= x << 1;
            end
          end
        end
        default: state <= U_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/rational_dot_product_mac.sv -----
// Top level of the rational dot-product multiply-accumulate block.
//
// Channel  Dir  Handshake              Beat contents
// s_axis   in   s_axis_tvalid/tready   one pair of rationals, first_pair in tuser
// m_axis   out  m_axis_tvalid/tready   reduced running sum plus status flags
//
// One beat is twenty serial operations on the shared unit: ten of them
// ACC_WIDTH-step divisions, plus binary gcds and shift-add multiplies.
// A zero denominator goes straight to S_OUT; an overflow ends the beat early.
// Synchronous reset puts the sum at +0/1 with overflow cleared.
// s_axis_tready is high only in idle; the result is copied to an output
// register, so the next beat can start while it waits; a newer result holds
// in S_OUT until that register is free.
module rational_dot_product_mac import rdpm_pkg::*; #(
  parameter int unsigned IN_WIDTH  = InWidthDef,
  parameter int unsigned ACC_WIDTH = AccWidthDef
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_negative[0], a_num[32:1], a_den[64:33], b_negative[65], b_num[97:66],
  // b_den[129:98], zeros above
  input  logic [135:0] s_axis_tdata,
  input  logic         s_axis_tuser,   // first_pair
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // sum_negative[0], sum_num[64:1], sum_den[128:65], overflowed[129],
  // bad_denominator[130], zeros above
  output logic [135:0] m_axis_tdata
);

  localparam int unsigned AW = ACC_WIDTH;

  typedef enum logic [18:0] {
    S_IDLE = 19'b0000000000000000001,
    S_G1   = 19'b0000000000000000010,  // g = gcd(an, ad)
    S_D1N  = 19'b0000000000000000100,  // an /= g
    S_D1D  = 19'b0000000000000001000,  // ad /= g
    S_G2   = 19'b0000000000000010000,  // g = gcd(bn, bd)
    S_D2N  = 19'b0000000000000100000,
    S_D2D  = 19'b0000000000001000000,
    S_MN   = 19'b0000000000010000000,  // pn = an*bn
    S_MD   = 19'b0000000000100000000,  // pd = ad*bd
    S_G3   = 19'b0000000001000000000,  // reduce product
    S_D3N  = 19'b0000000010000000000,
    S_D3D  = 19'b0000000100000000000,
    S_GC   = 19'b0000001000000000000,  // c = gcd(acc_den, pd)
    S_DAX  = 19'b0000010000000000000,  // ax = pd / c
    S_DBX  = 19'b0000100000000000000,  // bx = acc_den / c
    S_MND  = 19'b0001000000000000000,  // nd = acc_den*ax; xn; yn follow
    S_MXN  = 19'b0010000000000000000,
    S_MYN  = 19'b0100000000000000000,
    S_OUT  = 19'b1000000000000000000
  } state_t;

  // Final reduction reuses S_G3 path via a phase flag.
  state_t               state;
  logic                 busy;     // unit op in flight
  logic                 fin;      // final reduction phase
  logic                 acc_neg;
  logic [AW-1:0]        acc_num, acc_den;
  logic                 ovf_seen;
  logic                 bad;
  logic                 p_neg;
  logic [AW-1:0]        an, ad, bn, bd, pn, pd, g, ax, bx, nd, xn;
  logic                 out_valid;
  logic [135:0]         out_data;
  logic [135:0]         sum_beat;

  unit_req_t            req;
  unit_stat_t           stat;
  logic [AW-1:0]        opa, opb, res;

  logic [IN_WIDTH-1:0]  in_an, in_ad, in_bn, in_bd;
  assign in_an = s_axis_tdata[1 +: IN_WIDTH];
  assign in_ad = s_axis_tdata[33 +: IN_WIDTH];
  assign in_bn = s_axis_tdata[66 +: IN_WIDTH];
  assign in_bd = s_axis_tdata[98 +: IN_WIDTH];

  rdpm_unit #(.ACC_WIDTH(ACC_WIDTH)) u_unit (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .opa  (opa),
    .opb  (opb),
    .stat (stat),
    .res  (res)
  );

  // Operand and opcode per step.
  always_comb begin
    opa       = '0;
    opb       = '0;
    req.op    = OP_GCD;
    req.start = !busy && (state != S_IDLE) && (state != S_OUT);
    unique case (state)
      S_G1:  begin opa = an; opb = ad; end
      S_D1N: begin opa = an; opb = g; req.op = OP_DIV; end
      S_D1D: begin opa = ad; opb = g; req.op = OP_DIV; end
      S_G2:  begin opa = bn; opb = bd; end
      S_D2N: begin opa = bn; opb = g; req.op = OP_DIV; end
      S_D2D: begin opa = bd; opb = g; req.op = OP_DIV; end
      S_MN:  begin opa = an; opb = bn; req.op = OP_MUL; end
      S_MD:  begin opa = ad; opb = bd; req.op = OP_MUL; end
      S_G3:  begin opa = pn; opb = pd; end
      S_D3N: begin opa = pn; opb = g; req.op = OP_DIV; end
      S_D3D: begin opa = pd; opb = g; req.op = OP_DIV; end
      S_GC:  begin opa = acc_den; opb = pd; end
      S_DAX: begin opa = pd; opb = g; req.op = OP_DIV; end
      S_DBX: begin opa = acc_den; opb = g; req.op = OP_DIV; end
      S_MND: begin opa = acc_den; opb = ax; req.op = OP_MUL; end
      S_MXN: begin opa = acc_num; opb = ax; req.op = OP_MUL; end
      S_MYN: begin opa = pn; opb = bx; req.op = OP_MUL; end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  assign s_axis_tready = (state == S_IDLE);

  logic [AW:0] add_w;
  assign add_w = {1'b0, xn} + {1'b0, res};

  // Result beat as it stands in the accumulator.
  always_comb begin
    sum_beat           = '0;
    sum_beat[0]        = acc_neg;
    sum_beat[1 +: AW]  = acc_num;
    sum_beat[65 +: AW] = acc_den;
    sum_beat[129]      = ovf_seen;
    sum_beat[130]      = bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      busy      <= 1'b0;
      fin       <= 1'b0;
      acc_neg   <= 1'b0;
      acc_num   <= '0;
      acc_den   <= AW'(1);
      ovf_seen  <= 1'b0;
      out_valid <= 1'b0;
      out_data  <= '0;
      bad       <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready && state != S_OUT) out_valid <= 1'b0;
      if (req.start) busy <= 1'b1;
      if (stat.done) busy <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            an    <= AW'(in_an);
            ad    <= AW'(in_ad);
            bn    <= AW'(in_bn);
            bd    <= AW'(in_bd);
            p_neg <= s_axis_tdata[0] ^ s_axis_tdata[65];
            fin   <= 1'b0;
            if (s_axis_tuser) begin
              acc_neg  <= 1'b0;
              acc_num  <= '0;
              acc_den  <= AW'(1);
              ovf_seen <= 1'b0;
            end
            if (in_ad == '0 || in_bd == '0) begin
              bad   <= 1'b1;
              state <= S_OUT;
            end else begin
              bad   <= 1'b0;
              state <= S_G1;
            end
          end
        end
        S_OUT: begin
          // Hold until the output register is empty or being drained.
          if (!out_valid || m_axis_tready) begin
            out_data  <= sum_beat;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          if (stat.done) begin
            unique case (state)
              S_G1:  begin g <= res; state <= S_D1N; end
              S_D1N: begin an <= res; state <= S_D1D; end
              S_D1D: begin ad <= res; state <= S_G2; end
              S_G2:  begin g <= res; state <= S_D2N; end
              S_D2N: begin bn <= res; state <= S_D2D; end
              S_D2D: begin bd <= res; state <= S_MN; end
              S_MN: begin
                pn <= res;
                if (stat.ovf) begin ovf_seen <= 1'b1; state <= S_OUT; end
                else state <= S_MD;
              end
              S_MD: begin
                pd <= res;
                if (stat.ovf) begin ovf_seen <= 1'b1; state <= S_OUT; end
                else state <= S_G3;
              end
              S_G3:  begin g <= res; state <= S_D3N; end
              S_D3N: begin pn <= res; state <= S_D3D; end
              S_D3D: begin
                if (fin) begin
                  // pn and the unit result hold the final reduced sum here.
                  acc_num <= pn;
                  acc_den <= (pn == '0) ? AW'(1) : res;
                  if (pn == '0) acc_neg <= 1'b0;
                  else acc_neg <= p_neg;
                  state <= S_OUT;
                end else begin
                  pd    <= res;
                  state <= S_GC;
                end
              end
              S_GC:  begin g <= res; state <= S_DAX; end
              S_DAX: begin ax <= res; state <= S_DBX; end
              S_DBX: begin bx <= res; state <= S_MND; end
              S_MND: begin
                nd <= res;
                if (stat.ovf) begin ovf_seen <= 1'b1; state <= S_OUT; end
                else state <= S_MXN;
              end
              S_MXN: begin
                xn <= res;
                if (stat.ovf) begin ovf_seen <= 1'b1; state <= S_OUT; end
                else state <= S_MYN;
              end
              S_MYN: begin
                if (stat.ovf) begin
                  ovf_seen <= 1'b1;
                  state    <= S_OUT;
                end else if (acc_neg == p_neg) begin
                  if (add_w[AW]) begin
                    ovf_seen <= 1'b1;
                    state    <= S_OUT;
                  end else begin
                    pn <= add_w[AW-1:0]; pd <= nd; p_neg <= acc_neg;
                    fin <= 1'b1; state <= S_G3;
                  end
                end else if (xn > res) begin
                  pn <= xn - res; pd <= nd; p_neg <= acc_neg;
                  fin <= 1'b1; state <= S_G3;
                end else begin
                  pn <= res - xn; pd <= nd; p_neg <= !acc_neg;
                  fin <= 1'b1; state <= S_G3;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule
